### sv/sle_pkg.sv
package sle_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ECHO,
    S_ERASE,
    S_CRLF,
    S_GPSLF,
    S_LINE,
    S_LEND
  } state_t;

  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_NUL = 8'd0;

  localparam logic [1:0] DEST_ECHO = 2'd0;
  localparam logic [1:0] DEST_CMD  = 2'd1;
  localparam logic [1:0] DEST_GPS  = 2'd2;

  localparam logic FUNC_RX  = 1'b0;
  localparam logic FUNC_ERR = 1'b1;

  localparam logic PORT_CON = 1'b0;
  localparam logic PORT_GPS = 1'b1;

endpackage

### sv/serial_line_editor_two_port_top.sv
// Flow: an accepted word is decoded the next cycle; any result words are then registered from the
//   echo, erase, CR/LF or line states (a GPS line first stores its LF), one result word per cycle
//   while out_ready holds. in_ready is high only in S_IDLE, so no new word is taken until the
//   sequencer is back in S_IDLE after the previous one.
// Reset: rst_n is synchronous, active low; it clears both cursors and the per-slot
//   valid bits, so an unwritten slot is treated as a line end, like a NUL, with no clearing pass.
module serial_line_editor_two_port_top #(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic       in_port,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_dest,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import sle_pkg::*;

  localparam int CW = $clog2(LINE_DEPTH);
  localparam int AW = $clog2(2 * LINE_DEPTH);
  localparam logic [CW-1:0] LAST_SLOT = CW'(LINE_DEPTH - 1);
  localparam logic [CW-1:0] GPS_MAX   = CW'(LINE_DEPTH - 3);

  state_t state_r, state_nxt;

  logic          func_r;
  logic          port_r;
  logic [7:0]    byte_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0][CW-1:0]         cursor_r, cursor_nxt;
  logic [1:0][LINE_DEPTH-1:0] vld_r, vld_nxt;

  logic [7:0]    mem [2*LINE_DEPTH];
  logic          mem_we;
  logic [CW-1:0] mem_wslot;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    rd_data_r;
  logic          rd_vld_r;

  logic          out_valid_r;
  logic [1:0]    out_dest_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          out_free;
  logic          out_load;
  logic [1:0]    ld_dest;
  logic [7:0]    ld_byte;
  logic          ld_last;

  logic [CW-1:0] cur;
  logic [1:0]    line_dest;
  logic          clr_port;
  logic          line_end;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_dest  = out_dest_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  assign out_free  = !out_valid_r || out_ready;
  assign cur       = cursor_r[port_r];
  assign line_dest = (port_r == PORT_GPS) ? DEST_GPS : DEST_CMD;
  assign line_end  = !rd_vld_r || (rd_data_r == CH_NUL);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    cursor_nxt = cursor_r;
    vld_nxt    = vld_r;
    mem_we     = 1'b0;
    mem_wslot  = cur;
    mem_wdata  = byte_r;
    out_load   = 1'b0;
    ld_dest    = DEST_ECHO;
    ld_byte    = byte_r;
    ld_last    = 1'b0;
    clr_port   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        cnt_nxt   = 2'd0;
        idx_nxt   = '0;
        if (func_r == FUNC_ERR) begin
          clr_port = 1'b1;
        end else if (byte_r == CH_LF) begin
          state_nxt = S_IDLE;
        end else if (byte_r == CH_BS || byte_r == CH_DEL) begin
          // step back and clear the slot under the new cursor
          if (cur != '0) begin
            cursor_nxt[port_r] = cur - 1'b1;
            vld_nxt[port_r][cur - 1'b1] = 1'b0;
            if (port_r == PORT_CON) begin
              state_nxt = S_ERASE;
            end
          end else begin
            vld_nxt[port_r][0] = 1'b0;
          end
        end else if (byte_r == CH_CR) begin
          if (port_r == PORT_CON) begin
            state_nxt = S_CRLF;
          end else if (cur <= GPS_MAX) begin
            mem_we    = 1'b1;
            mem_wdata = CH_CR;
            vld_nxt[port_r][cur] = 1'b1;
            state_nxt = S_GPSLF;
          end else begin
            clr_port = 1'b1;
          end
        end else begin
          mem_we = 1'b1;
          vld_nxt[port_r][cur] = 1'b1;
          if (cur != LAST_SLOT) begin
            cursor_nxt[port_r] = cur + 1'b1;
            if (port_r == PORT_CON) begin
              state_nxt = S_ECHO;
            end
          end
        end
      end
      S_ECHO: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ERASE: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_byte  = (cnt_r == 2'd1) ? CH_SP : CH_BS;
          ld_last  = (cnt_r == 2'd2);
          cnt_nxt  = cnt_r + 2'd1;
          if (cnt_r == 2'd2) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CRLF: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_byte  = (cnt_r == 2'd0) ? CH_CR : CH_LF;
          cnt_nxt  = cnt_r + 2'd1;
          if (cnt_r != 2'd0) begin
            state_nxt = S_LINE;
          end
        end
      end
      S_GPSLF: begin
        mem_we    = 1'b1;
        mem_wslot = cur + 1'b1;
        mem_wdata = CH_LF;
        vld_nxt[port_r][cur + 1'b1] = 1'b1;
        state_nxt = S_LINE;
      end
      S_LINE: begin
        // read data tracks idx_nxt, so a stall keeps the same slot on the read port
        if (out_free) begin
          out_load = 1'b1;
          ld_dest  = line_dest;
          if (line_end) begin
            ld_byte   = CH_NUL;
            ld_last   = 1'b1;
            clr_port  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ld_byte = rd_data_r;
            if (idx_r == LAST_SLOT) begin
              state_nxt = S_LEND;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
      end
      S_LEND: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_dest   = line_dest;
          ld_byte   = CH_NUL;
          ld_last   = 1'b1;
          clr_port  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (clr_port) begin
      vld_nxt[port_r]    = '0;
      cursor_nxt[port_r] = '0;
    end
  end

  assign mem_waddr = (port_r == PORT_GPS) ? AW'(LINE_DEPTH) + AW'(mem_wslot) : AW'(mem_wslot);
  assign mem_raddr = (port_r == PORT_GPS) ? AW'(LINE_DEPTH) + AW'(idx_nxt) : AW'(idx_nxt);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
    rd_vld_r  <= vld_r[port_r][idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      idx_r    <= '0;
      cursor_r <= '0;
      vld_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      cursor_r <= cursor_nxt;
      vld_r    <= vld_nxt;
    end
  end

  // hold the input word for the decode cycle
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      port_r <= in_port;
      byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dest_r <= ld_dest;
      out_byte_r <= ld_byte;
      out_last_r <= ld_last;
    end
  end

`ifndef ASSERT_OFF
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r[0] <= LAST_SLOT) && (cursor_r[1] <= LAST_SLOT))
    else $error("cursor beyond last slot");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output word overwritten before taken");

  a_line_closes: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LINE || state_r == S_LEND) && state_nxt == S_IDLE)
      |-> (out_load && ld_last && ld_byte == CH_NUL))
    else $error("line left without end word");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ld_last) |=> (state_r == S_IDLE))
    else $error("last word loaded but sequencer busy");
`endif

endmodule
